[rtl/qsse_pkg.sv]
// Shared types and constants of the quad to stereo surround encoder.
`timescale 1ns / 1ps
`default_nettype none
package qsse_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 24;
    localparam int TAPCFG_BITS = 11;
    localparam int INDEX_BITS  = 10;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Mixing gains in Q20.
    localparam logic signed [20:0] K044  = 21'sd461373;
    localparam logic signed [20:0] K028  = 21'sd293601;
    localparam logic signed [20:0] KN028 = -21'sd293601;

    typedef enum logic [1:0] {
        OP_FRAME   = 2'd0,
        OP_LOAD_BP = 2'd1,
        OP_LOAD_PH = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_MODE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REAR_FILTER_ON = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_TAPS     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REAR_TAPS      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REAR_GAIN      = 3'd4;

    typedef struct packed {
        t_op                             op;
        logic signed [SAMPLE_BITS-1:0]   front_left;
        logic signed [SAMPLE_BITS-1:0]   front_right;
        logic signed [SAMPLE_BITS-1:0]   center;
        logic signed [SAMPLE_BITS-1:0]   rear;
        logic        [INDEX_BITS-1:0]    tap_index;
        logic signed [COEF_BITS-1:0]     coef_first;
        logic signed [COEF_BITS-1:0]     coef_second;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } t_out_item;

endpackage
`default_nettype wire

[rtl/quad_to_stereo_surround_encoder.sv]
// Top level of the quad to stereo matrix surround encoder.
//
// A frame transfer yields one stereo result. A frame passes through the bandpass
// when it is enabled, through the Hilbert pair in phase mode, and then through
// the mixing states S_MIX1 and S_MIX2; each tap costs one read of the delay
// line memory and the coefficient memories, so the tap counts set the frame
// time. A stalled output holds the block in S_MIX2. A coefficient load is
// written as it is accepted, and the block stays ready. After reset and after
// a clear operation the block sweeps both delay lines, one entry per cycle,
// over all 2**clog2(MAX_TAPS) entries (1024 by default), during which no input
// is taken. A finished result waits in the output register while the next item
// is taken.
`timescale 1ns / 1ps
`default_nettype none
module quad_to_stereo_surround_encoder
    import qsse_pkg::*;
#(
    parameter int MAX_TAPS = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire t_in_item                 i_in_data,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output t_out_item                     o_out_data,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int LINE_AW = (MAX_TAPS > 2) ? $clog2(MAX_TAPS) : 1;
    localparam int LINE_D  = 1 << LINE_AW;
    localparam int CAW     = LINE_AW;
    localparam int TW      = $clog2(MAX_TAPS + 1);
    localparam int PRW     = SAMPLE_BITS + COEF_BITS;
    localparam int ACCW    = PRW + LINE_AW;
    localparam int PW      = ACCW - 14;
    localparam int MIXW    = PW + SAMPLE_BITS + 2;

    localparam logic signed [ACCW-1:0] A_HALF20 = ACCW'(1 << 19);
    localparam logic signed [ACCW-1:0] A_HALF14 = ACCW'(1 << 13);
    localparam logic signed [ACCW-1:0] A_SMAX = ACCW'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACCW-1:0] A_SMIN = ACCW'(-(1 << (SAMPLE_BITS - 1)));
    localparam logic signed [MIXW-1:0] M_HALF20 = MIXW'(1 << 19);
    localparam logic signed [MIXW-1:0] M_SMAX = MIXW'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [MIXW-1:0] M_SMIN = MIXW'(-(1 << (SAMPLE_BITS - 1)));

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_BP_WR  = 10'b00_0000_0100,
        S_BP_RUN = 10'b00_0000_1000,
        S_BP_END = 10'b00_0001_0000,
        S_PH_WR  = 10'b00_0010_0000,
        S_PH_RUN = 10'b00_0100_0000,
        S_PH_END = 10'b00_1000_0000,
        S_MIX1   = 10'b01_0000_0000,
        S_MIX2   = 10'b10_0000_0000
    } t_state;

    // Memories.
    logic signed [SAMPLE_BITS-1:0] rear_line  [LINE_D];
    logic signed [SAMPLE_BITS-1:0] phase_line [LINE_D];
    logic signed [COEF_BITS-1:0]   bp_coefs   [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   ph_coefs1  [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   ph_coefs2  [MAX_TAPS];

    t_state r_state, n_state;

    logic                      r_phase_mode, r_rear_filter_on;
    logic [TAPCFG_BITS-1:0]    r_phase_taps, r_rear_taps;
    logic signed [15:0]        r_rear_gain;

    t_in_item                  r_item;
    logic [LINE_AW-1:0]        r_clr;
    logic [LINE_AW-1:0]        r_rear_pos, r_phase_pos;
    logic [TW-1:0]             r_k, r_t;
    logic [LINE_AW-1:0]        r_addr, r_mask;
    logic                      r_rd_v, r_pr_v;
    logic signed [SAMPLE_BITS-1:0] r_rl_q, r_pl_q;
    logic signed [COEF_BITS-1:0]   r_bp_q, r_c1_q, r_c2_q;
    logic signed [PRW-1:0]     r_pr1, r_pr2;
    logic signed [ACCW-1:0]    r_acc1, r_acc2;
    logic signed [SAMPLE_BITS-1:0] r_rear;
    logic signed [PW-1:0]      r_ph1, r_ph2;
    logic signed [MIXW-1:0]    r_m_fl, r_m_fr, r_m_c, r_m_rl, r_m_rr;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic                      in_acc;
    logic [TW-1:0]             bp_t, ph_t;
    logic [LINE_AW-1:0]        bp_mask, ph_mask;
    logic [LINE_AW-1:0]        bp_w, ph_w;
    logic                      coef_ok;
    logic [CAW-1:0]            coef_addr;
    logic signed [SAMPLE_BITS-1:0] mac_smp;
    logic signed [COEF_BITS-1:0]   mac_c1;
    logic signed [ACCW-1:0]    bp_rnd, ph_rnd1, ph_rnd2;
    logic signed [SAMPLE_BITS-1:0] bp_sat;
    logic signed [MIXW-1:0]    sum_l, sum_r, rnd_l, rnd_r;
    logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;
    logic                      run_done, out_free;

    function automatic logic [TW-1:0] clamp_taps(input logic [TAPCFG_BITS-1:0] t);
        logic [TW-1:0] res;
        if (32'(t) > 32'(MAX_TAPS)) begin
            res = TW'(MAX_TAPS);
        end else begin
            res = TW'(t);
        end
        return res;
    endfunction

    // Ring size minus one: (t - 1) with every bit below its top bit set.
    function automatic logic [LINE_AW-1:0] ring_mask(input logic [TW-1:0] t);
        logic [LINE_AW-1:0] tm1, m;
        logic               acc;
        tm1 = LINE_AW'(t - TW'(1));
        acc = 1'b0;
        m   = '0;
        for (int i = LINE_AW - 1; i >= 0; i--) begin
            acc  = acc | tm1[i];
            m[i] = acc;
        end
        if (t == '0) begin
            m = '0;
        end
        return m;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_acc(input logic signed [ACCW-1:0] x);
        logic signed [SAMPLE_BITS-1:0] res;
        if (x > A_SMAX) begin
            res = SAMPLE_BITS'(A_SMAX);
        end else if (x < A_SMIN) begin
            res = SAMPLE_BITS'(A_SMIN);
        end else begin
            res = SAMPLE_BITS'(x);
        end
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_mix(input logic signed [MIXW-1:0] x);
        logic signed [SAMPLE_BITS-1:0] res;
        if (x > M_SMAX) begin
            res = SAMPLE_BITS'(M_SMAX);
        end else if (x < M_SMIN) begin
            res = SAMPLE_BITS'(M_SMIN);
        end else begin
            res = SAMPLE_BITS'(x);
        end
        return res;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        bp_t    = clamp_taps(r_rear_taps);
        ph_t    = clamp_taps(r_phase_taps);
        bp_mask = ring_mask(bp_t);
        ph_mask = ring_mask(ph_t);
        bp_w    = r_rear_pos & bp_mask;
        ph_w    = r_phase_pos & ph_mask;
    end

    assign coef_ok   = 32'(i_in_data.tap_index) < 32'(MAX_TAPS);
    assign coef_addr = CAW'(i_in_data.tap_index);

    // Coefficient memories: written by load transfers, read at the tap counter.
    always_ff @(posedge i_clk) begin
        if (in_acc && coef_ok && (i_in_data.op == OP_LOAD_BP)) begin
            bp_coefs[coef_addr] <= i_in_data.coef_first;
        end
        if (in_acc && coef_ok && (i_in_data.op == OP_LOAD_PH)) begin
            ph_coefs1[coef_addr] <= i_in_data.coef_first;
            ph_coefs2[coef_addr] <= i_in_data.coef_second;
        end
        r_bp_q <= bp_coefs[r_k[CAW-1:0]];
        r_c1_q <= ph_coefs1[r_k[CAW-1:0]];
        r_c2_q <= ph_coefs2[r_k[CAW-1:0]];
    end

    // Delay line memories.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            rear_line[r_clr]  <= '0;
            phase_line[r_clr] <= '0;
        end
        if (r_state == S_BP_WR) begin
            rear_line[bp_w] <= r_item.rear;
        end
        if (r_state == S_PH_WR) begin
            phase_line[ph_w] <= r_rear;
        end
        r_rl_q <= rear_line[r_addr];
        r_pl_q <= phase_line[r_addr];
    end

    assign mac_smp = (r_state == S_PH_RUN) ? r_pl_q : r_rl_q;
    assign mac_c1  = (r_state == S_PH_RUN) ? r_c1_q : r_bp_q;

    assign run_done = (r_k == r_t) && !r_rd_v && !r_pr_v;

    always_comb begin
        bp_rnd  = (r_acc1 + A_HALF20) >>> 20;
        bp_sat  = sat_acc(bp_rnd);
        ph_rnd1 = (r_acc1 + A_HALF14) >>> 14;
        ph_rnd2 = (r_acc2 + A_HALF14) >>> 14;
        sum_l   = r_m_fl + r_m_c + r_m_rl;
        sum_r   = r_m_fr + r_m_c + r_m_rr;
        rnd_l   = (sum_l + M_HALF20) >>> 20;
        rnd_r   = (sum_r + M_HALF20) >>> 20;
        sat_l   = sat_mix(rnd_l);
        sat_r   = sat_mix(rnd_r);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.op)
                        OP_FRAME: begin
                            if (r_rear_filter_on) begin
                                n_state = S_BP_WR;
                            end else if (r_phase_mode) begin
                                n_state = S_PH_WR;
                            end else begin
                                n_state = S_MIX1;
                            end
                        end
                        OP_CLEAR: n_state = S_CLEAR;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_BP_WR:  n_state = S_BP_RUN;
            S_BP_RUN: begin
                if (run_done) begin
                    n_state = S_BP_END;
                end
            end
            S_BP_END: n_state = r_phase_mode ? S_PH_WR : S_MIX1;
            S_PH_WR:  n_state = S_PH_RUN;
            S_PH_RUN: begin
                if (run_done) begin
                    n_state = S_PH_END;
                end
            end
            S_PH_END: n_state = S_MIX1;
            S_MIX1:   n_state = S_MIX2;
            S_MIX2: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_clr            <= '0;
            r_rear_pos       <= '0;
            r_phase_pos      <= '0;
            r_rd_v           <= 1'b0;
            r_pr_v           <= 1'b0;
            r_out_valid      <= 1'b0;
            r_phase_mode     <= 1'b0;
            r_rear_filter_on <= 1'b0;
            r_phase_taps     <= TAPCFG_BITS'(64);
            r_rear_taps      <= TAPCFG_BITS'(64);
            r_rear_gain      <= 16'sd4588;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PHASE_MODE:     r_phase_mode     <= i_cfg_data[0];
                    CFG_REAR_FILTER_ON: r_rear_filter_on <= i_cfg_data[0];
                    CFG_PHASE_TAPS:     r_phase_taps     <= i_cfg_data[TAPCFG_BITS-1:0];
                    CFG_REAR_TAPS:      r_rear_taps      <= i_cfg_data[TAPCFG_BITS-1:0];
                    CFG_REAR_GAIN:      r_rear_gain      <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + LINE_AW'(1);
            end
            if (in_acc && (i_in_data.op == OP_CLEAR)) begin
                r_clr       <= '0;
                r_rear_pos  <= '0;
                r_phase_pos <= '0;
            end
            if (r_state == S_BP_WR) begin
                r_rear_pos <= (bp_w + LINE_AW'(1)) & bp_mask;
            end
            if (r_state == S_PH_WR) begin
                r_phase_pos <= (ph_w + LINE_AW'(1)) & ph_mask;
            end

            r_rd_v <= ((r_state == S_BP_RUN) || (r_state == S_PH_RUN)) && (r_k != r_t);
            r_pr_v <= r_rd_v;

            if (r_state == S_MIX2 && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: tap sequencer, multiply-accumulate and mixing.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (r_state == S_IDLE) begin
            r_rear <= i_in_data.rear;
        end
        case (r_state)
            S_BP_WR: begin
                r_k    <= '0;
                r_t    <= bp_t;
                r_mask <= bp_mask;
                r_addr <= (bp_w - LINE_AW'(bp_t)) & bp_mask;
                r_acc1 <= '0;
                r_acc2 <= '0;
            end
            S_PH_WR: begin
                r_k    <= '0;
                r_t    <= ph_t;
                r_mask <= ph_mask;
                r_addr <= (ph_w - LINE_AW'(ph_t)) & ph_mask;
                r_acc1 <= '0;
                r_acc2 <= '0;
            end
            S_BP_RUN, S_PH_RUN: begin
                if (r_k != r_t) begin
                    r_k    <= r_k + TW'(1);
                    r_addr <= (r_addr + LINE_AW'(1)) & r_mask;
                end
                if (r_pr_v) begin
                    r_acc1 <= r_acc1 + ACCW'(r_pr1);
                    r_acc2 <= r_acc2 + ACCW'(r_pr2);
                end
            end
            S_BP_END: r_rear <= bp_sat;
            S_PH_END: begin
                r_ph1 <= PW'(ph_rnd1);
                r_ph2 <= PW'(ph_rnd2);
            end
            S_MIX1: begin
                r_m_fl <= MIXW'(r_item.front_left * K044);
                r_m_fr <= MIXW'(r_item.front_right * K044);
                r_m_c  <= MIXW'(r_item.center * K028);
                if (r_phase_mode) begin
                    r_m_rl <= MIXW'(r_ph1 * r_rear_gain);
                    r_m_rr <= MIXW'(r_ph2 * r_rear_gain);
                end else begin
                    r_m_rl <= MIXW'(r_rear * K028);
                    r_m_rr <= MIXW'(r_rear * KN028);
                end
            end
            S_MIX2: begin
                if (out_free) begin
                    r_out.out_left  <= sat_l;
                    r_out.out_right <= sat_r;
                end
            end
            default: ;
        endcase
        if (r_rd_v) begin
            r_pr1 <= mac_smp * mac_c1;
            r_pr2 <= mac_smp * r_c2_q;
        end
    end

endmodule
`default_nettype wire

[rtl/qsse_checker.sv]
// Port-level checks of the surround encoder and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qsse_checker
    import qsse_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_data
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("stalled result changed");

    // A frame or a clear keeps the block busy in the following cycle.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready &&
        (i_in_data.op == OP_FRAME || i_in_data.op == OP_CLEAR) |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // A new result only appears while the block was working on a frame.
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result without work");

endmodule

bind quad_to_stereo_surround_encoder qsse_checker u_qsse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
`default_nettype wire

[bench/tb_quad_to_stereo_surround_encoder.sv]
// Self-checking testbench of the quad to stereo surround encoder.
`timescale 1ns / 1ps
module tb_quad_to_stereo_surround_encoder;
    import qsse_pkg::*;

    localparam int TAP_SLOTS = 1024;
    localparam int LOADED_SLOTS = 48;
    localparam int DRAIN_CYCLES = 2200;

    class surround_scoreboard;
        bit        phase_mode;
        bit        rear_filter_on;
        int        phase_taps;
        int        rear_taps;
        longint    rear_gain;
        int        rear_hist[TAP_SLOTS];
        int        phase_hist[TAP_SLOTS];
        int        rear_pos;
        int        phase_pos;
        int        bp_coef[TAP_SLOTS];
        int        ph_coef_a[TAP_SLOTS];
        int        ph_coef_b[TAP_SLOTS];
        t_out_item stereo_q[$];
        int        errors;

        function new();
            phase_mode = 0;
            rear_filter_on = 0;
            phase_taps = 64;
            rear_taps = 64;
            rear_gain = 4588;
            rear_pos = 0;
            phase_pos = 0;
            errors = 0;
            foreach (rear_hist[i]) begin
                rear_hist[i] = 0;
                phase_hist[i] = 0;
                bp_coef[i] = 0;
                ph_coef_a[i] = 0;
                ph_coef_b[i] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_PHASE_MODE:     phase_mode = val[0];
                CFG_REAR_FILTER_ON: rear_filter_on = val[0];
                CFG_PHASE_TAPS:     phase_taps = int'(val[TAPCFG_BITS-1:0]);
                CFG_REAR_TAPS:      rear_taps = int'(val[TAPCFG_BITS-1:0]);
                CFG_REAR_GAIN:      rear_gain = longint'($signed(val));
                default: ;
            endcase
        endfunction

        function longint round_to(longint x, int n);
            return (x + (64'sd1 <<< (n - 1))) >>> n;
        endfunction

        function longint clip16(longint x);
            if (x > 32767) return 32767;
            if (x < -32768) return -32768;
            return x;
        endfunction

        function int ring_of(int t);
            int r;
            r = 1;
            while (r < t) r = r << 1;
            return r;
        endfunction

        function t_out_item encode_frame(t_in_item it);
            longint    rear, left, right, acc, a1, a2, s;
            int        t, r, w;
            t_out_item res;
            rear = $signed(it.rear);
            if (rear_filter_on) begin
                t = (rear_taps > TAP_SLOTS) ? TAP_SLOTS : rear_taps;
                r = ring_of(t);
                w = rear_pos & (r - 1);
                rear_hist[w] = int'(rear);
                acc = 0;
                for (int k = 0; k < t; k++)
                    acc += longint'(bp_coef[k]) * rear_hist[(w - t + k) & (r - 1)];
                rear = clip16(round_to(acc, 20));
                rear_pos = (w + 1) & (r - 1);
            end
            left = longint'($signed(it.front_left)) * K044 + longint'($signed(it.center)) * K028;
            right = longint'($signed(it.front_right)) * K044 + longint'($signed(it.center)) * K028;
            if (phase_mode) begin
                t = (phase_taps > TAP_SLOTS) ? TAP_SLOTS : phase_taps;
                r = ring_of(t);
                w = phase_pos & (r - 1);
                phase_hist[w] = int'(rear);
                a1 = 0;
                a2 = 0;
                for (int k = 0; k < t; k++) begin
                    s = phase_hist[(w - t + k) & (r - 1)];
                    a1 += longint'(ph_coef_a[k]) * s;
                    a2 += longint'(ph_coef_b[k]) * s;
                end
                phase_pos = (w + 1) & (r - 1);
                left += round_to(a1, 14) * rear_gain;
                right += round_to(a2, 14) * rear_gain;
            end else begin
                left += rear * K028;
                right -= rear * K028;
            end
            res.out_left = 16'(clip16(round_to(left, 20)));
            res.out_right = 16'(clip16(round_to(right, 20)));
            return res;
        endfunction

        function void note_input(t_in_item it);
            case (it.op)
                OP_LOAD_BP: bp_coef[it.tap_index] = int'($signed(it.coef_first));
                OP_LOAD_PH: begin
                    ph_coef_a[it.tap_index] = int'($signed(it.coef_first));
                    ph_coef_b[it.tap_index] = int'($signed(it.coef_second));
                end
                OP_CLEAR: begin
                    foreach (rear_hist[i]) begin
                        rear_hist[i] = 0;
                        phase_hist[i] = 0;
                    end
                    rear_pos = 0;
                    phase_pos = 0;
                end
                default: stereo_q.push_back(encode_frame(it));
            endcase
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (stereo_q.size() == 0) begin
                report("unexpected result", $signed(got.out_left), 0);
            end else begin
                want = stereo_q.pop_front();
                if (got.out_left !== want.out_left)
                    report("out_left", $signed(got.out_left), $signed(want.out_left));
                if (got.out_right !== want.out_right)
                    report("out_right", $signed(got.out_right), $signed(want.out_right));
            end
        endtask

        function int pending();
            return stereo_q.size();
        endfunction
    endclass

    logic                     i_clk = 0;
    logic                     i_rst_n = 0;
    logic                     i_in_valid = 0;
    logic                     o_in_ready;
    t_in_item                 i_in_data = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 0;
    t_out_item                o_out_data;
    logic                     i_cfg_valid = 0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    surround_scoreboard sb = new();
    int burst_left = 0;
    bit hold_req = 0;

    quad_to_stereo_surround_encoder dut (.*);

    always #5 i_clk = ~i_clk;

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
    end

    // Receiver: ready follows a stall pattern that is picked anew at random; a requested hold-off
    // keeps ready low long enough for the block to back up.
    initial begin
        int mode;
        int cnt;
        mode = 0;
        cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_out_ready <= 0;
                repeat (600) @(posedge i_clk);
            end else begin
                cnt++;
                if (cnt % 64 == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: i_out_ready <= 1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task send_item(t_in_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
    endtask

    task write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 0;
    endtask

    task wait_idle();
        i_in_valid <= 0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function logic [23:0] rand_coef();
        if ($urandom_range(0, 3) == 0) return 24'($urandom);
        return 24'($urandom_range(0, 65535) - 32768);
    endfunction

    function t_in_item rand_item();
        t_in_item it;
        int pick;
        pick = $urandom_range(0, 99);
        it.op = (pick < 80) ? OP_FRAME : (pick < 88) ? OP_LOAD_BP :
                (pick < 96) ? OP_LOAD_PH : OP_CLEAR;
        it.front_left = rand_sample();
        it.front_right = rand_sample();
        it.center = rand_sample();
        it.rear = rand_sample();
        it.tap_index = 10'($urandom);
        it.coef_first = rand_coef();
        it.coef_second = rand_coef();
        return it;
    endfunction

    function t_in_item frame_of(logic [15:0] fl, logic [15:0] fr, logic [15:0] c,
                                logic [15:0] r);
        t_in_item it;
        it = rand_item();
        it.op = OP_FRAME;
        it.front_left = fl;
        it.front_right = fr;
        it.center = c;
        it.rear = r;
        return it;
    endfunction

    function t_in_item load_of(t_op op, int idx, logic [23:0] c1, logic [23:0] c2);
        t_in_item it;
        it = rand_item();
        it.op = op;
        it.tap_index = 10'(idx);
        it.coef_first = c1;
        it.coef_second = c2;
        return it;
    endfunction

    task setup(bit pm, bit rf, int pt, int rt, int gain);
        wait_idle();
        write_reg(CFG_PHASE_MODE, 16'(pm));
        write_reg(CFG_REAR_FILTER_ON, 16'(rf));
        write_reg(CFG_PHASE_TAPS, 16'(pt));
        write_reg(CFG_REAR_TAPS, 16'(rt));
        write_reg(CFG_REAR_GAIN, 16'(gain));
    endtask

    task run_random(int n);
        for (int i = 0; i < n; i++) send_item(rand_item());
    endtask

    initial begin
        t_in_item it;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: sample extremes, both sign edges, a clear and edge slots.
        send_item(frame_of(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        send_item(frame_of(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_item(frame_of(16'h7fff, 16'h8000, 16'h0000, 16'h8000));
        send_item(frame_of(16'h8000, 16'h7fff, 16'h0000, 16'h7fff));
        send_item(frame_of(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(frame_of(16'hffff, 16'h0001, 16'hffff, 16'h0001));
        send_item(load_of(OP_LOAD_BP, 0, 24'h7fffff, 24'h800000));
        send_item(load_of(OP_LOAD_PH, 1023, 24'h800000, 24'h7fffff));
        it = frame_of(16'h1234, 16'hedcb, 16'h4000, 16'hc000);
        it.op = OP_CLEAR;
        send_item(it);
        send_item(frame_of(16'h0100, 16'hff00, 16'h0010, 16'h7fff));

        // Every coefficient slot that a filter reads gets a value first; tap
        // counts below stay within the loaded slots.
        for (int i = 0; i < LOADED_SLOTS; i++) begin
            send_item(load_of(OP_LOAD_BP, i, rand_coef(), rand_coef()));
            send_item(load_of(OP_LOAD_PH, i, rand_coef(), rand_coef()));
        end
        send_item(load_of(OP_LOAD_BP, 1023, 24'h800000, 24'h0));
        send_item(load_of(OP_LOAD_PH, 0, 24'h7fffff, 24'h800000));

        // Largest loaded tap counts and gain extremes.
        setup(1, 1, LOADED_SLOTS, LOADED_SLOTS, 16'h8000);
        for (int i = 0; i < 5; i++) send_item(frame_of(rand_sample(), rand_sample(),
                                                       rand_sample(), rand_sample()));
        setup(1, 0, 2, 2, 16'h7fff);
        for (int i = 0; i < 5; i++) send_item(frame_of(16'h7fff, 16'h8000,
                                                       rand_sample(), rand_sample()));
        setup(0, 1, 2, 2, 0);
        for (int i = 0; i < 4; i++) send_item(frame_of(rand_sample(), rand_sample(),
                                                       rand_sample(), rand_sample()));

        // Back pressure: fast frames while the receiver holds off.
        setup(1, 1, 3, 2, 4588);
        hold_req = 1;
        run_random(30);

        for (int p = 0; p < 9; p++) begin
            setup(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(2, 40), 2 * $urandom_range(1, 20), $urandom);
            run_random(15);
        end

        wait_idle();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

[quad_to_stereo_surround_encoder.f]
rtl/qsse_pkg.sv
rtl/quad_to_stereo_surround_encoder.sv
rtl/qsse_checker.sv
bench/tb_quad_to_stereo_surround_encoder.sv
